>>> rtl/equal_partition_checker_assert.svh
// Assertion macros for the equal partition checker.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef EQUAL_PARTITION_CHECKER_ASSERT_SVH
`define EQUAL_PARTITION_CHECKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPC_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("equal_partition_checker: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EPC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("equal_partition_checker: assertion failed");

`endif

>>> rtl/epc_pkg.sv
// Shared constants and types for the equal partition checker.
// Used by the top level and the port checker; depends on nothing.
package epc_pkg;

    localparam int MAX_TOTAL   = 1024;
    localparam int VALUE_WIDTH = 8;

    localparam int WORD_W   = 64;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int NWORDS   = MAX_TOTAL / WORD_W + 1;
    localparam int ADDR_W   = $clog2(NWORDS);
    localparam int TOTAL_W  = $clog2(MAX_TOTAL + 1);
    localparam int SUM_W    = ((TOTAL_W > VALUE_WIDTH) ? TOTAL_W : VALUE_WIDTH) + 1;
    localparam int TOP_BITS = MAX_TOTAL % WORD_W + 1;

    typedef logic [WORD_W-1:0] word_t;

    localparam word_t TOP_MASK = word_t'({TOP_BITS{1'b1}});

endpackage

>>> rtl/epc_ram.sv
// Generic RAM with one write port and two registered read ports.
// Stand-alone; sized by its width and depth parameters.
module epc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 17,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    output logic [WIDTH-1:0]  rdata_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> rtl/equal_partition_checker.sv
// Equal partition checker: subset-sum bitset kept as NWORDS 64-bit words in a RAM.
// A value v > 0 is folded in by a word loop through the shared shift-OR unit (S_PRIME,
// S_RUN, S_DRAIN), from the top word down to word v/64; v = 0 skips the loop. A last
// request then passes S_CHK_RD and S_CHK for the half-sum lookup before the result is loaded.
// Reset, and every result, return the bitset to {0} at once through per-word valid bits.
// Depends on epc_pkg and epc_ram.
module equal_partition_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [epc_pkg::VALUE_WIDTH-1:0] value,
    input  logic                            last,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            can_split,
    output logic                            total_odd,
    output logic                            sum_overflow
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PRIME  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_CHK_RD = 3'd4;
    localparam logic [2:0] S_CHK    = 3'd5;

    localparam logic [epc_pkg::ADDR_W-1:0] LAST_ADDR = epc_pkg::ADDR_W'(epc_pkg::NWORDS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [epc_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic                          ovf_reg, ovf_next;
    logic                          last_reg, last_next;
    logic [epc_pkg::ADDR_W-1:0]    s_reg, s_next;
    logic [epc_pkg::ADDR_W-1:0]    i_reg, i_next;
    logic [epc_pkg::ADDR_W-1:0]    ws_reg, ws_next;
    logic [epc_pkg::BIT_W-1:0]     bs_reg, bs_next;
    logic [epc_pkg::NWORDS-1:0]    word_vld_reg, word_vld_next;
    logic                          wr_vld_reg, wr_vld_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          split_reg, split_next;
    logic                          odd_reg, odd_next;
    logic                          sovf_reg, sovf_next;

    logic [epc_pkg::ADDR_W-1:0]    a_addr_reg, b_addr_reg;
    logic                          a_vld_reg, b_vld_reg, lo_zero_reg;
    epc_pkg::word_t                hi_reg;

    logic [epc_pkg::ADDR_W-1:0]    a_addr, half_addr;
    logic [epc_pkg::TOTAL_W-2:0]   half;
    logic [epc_pkg::SUM_W-1:0]     val_ext, sum_ext, ws_full;
    logic                          skip;
    epc_pkg::word_t                a_rdata, b_rdata, eff_a, eff_b, lo, shifted, new_word;
    logic [2*epc_pkg::WORD_W-1:0]  pair;
    logic                          accept, finish;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign val_ext = epc_pkg::SUM_W'(value);
    assign sum_ext = epc_pkg::SUM_W'(total_reg) + val_ext;
    assign ws_full = val_ext >> epc_pkg::BIT_W;
    assign skip    = (val_ext == '0) || (ws_full >= epc_pkg::SUM_W'(epc_pkg::NWORDS));

    assign half      = total_reg[epc_pkg::TOTAL_W-1:1];
    assign half_addr = epc_pkg::ADDR_W'(half >> epc_pkg::BIT_W);

    always_comb
    begin
        case (state_reg)
            S_PRIME: a_addr = s_reg;
            S_RUN:   a_addr = (s_reg == '0) ? '0 : s_reg - 1'b1;
            default: a_addr = half_addr;
        endcase
    end

    epc_ram #(
        .WIDTH (epc_pkg::WORD_W),
        .DEPTH (epc_pkg::NWORDS)
    ) u_epc_ram (
        .clk     (clk),
        .we      (wr_vld_reg),
        .waddr   (b_addr_reg),
        .wdata   (new_word),
        .raddr_a (a_addr),
        .rdata_a (a_rdata),
        .raddr_b (i_reg),
        .rdata_b (b_rdata)
    );

    // A word never written since the last clear reads as its reset value.
    assign eff_a = a_vld_reg ? a_rdata : epc_pkg::word_t'(a_addr_reg == '0);
    assign eff_b = b_vld_reg ? b_rdata : epc_pkg::word_t'(b_addr_reg == '0);

    assign lo      = lo_zero_reg ? '0 : eff_a;
    assign pair    = {hi_reg, lo} << bs_reg;
    assign shifted = pair[2*epc_pkg::WORD_W-1:epc_pkg::WORD_W];

    always_comb
    begin
        new_word = eff_b | shifted;
        if (b_addr_reg == LAST_ADDR)
        begin
            new_word = new_word & epc_pkg::TOP_MASK;
        end
    end

    assign finish = (state_reg == S_CHK) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        s_next         = s_reg;
        i_next         = i_reg;
        ws_next        = ws_reg;
        bs_next        = bs_reg;
        word_vld_next  = word_vld_reg;
        wr_vld_next    = 1'b0;
        split_next     = split_reg;
        odd_next       = odd_reg;
        sovf_next      = sovf_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (wr_vld_reg)
        begin
            word_vld_next[b_addr_reg] = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    total_next = epc_pkg::TOTAL_W'(sum_ext);
                    ovf_next   = ovf_reg || (sum_ext > epc_pkg::SUM_W'(epc_pkg::MAX_TOTAL));
                    last_next  = last;
                    ws_next    = epc_pkg::ADDR_W'(ws_full);
                    bs_next    = val_ext[epc_pkg::BIT_W-1:0];
                    s_next     = LAST_ADDR - epc_pkg::ADDR_W'(ws_full);
                    i_next     = LAST_ADDR;
                    if (skip)
                    begin
                        state_next = last ? S_CHK_RD : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_PRIME;
                    end
                end
            end
            S_PRIME:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                wr_vld_next = 1'b1;
                if (i_reg == ws_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    s_next = s_reg - 1'b1;
                    i_next = i_reg - 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = last_reg ? S_CHK_RD : S_IDLE;
            end
            S_CHK_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (finish)
                begin
                    split_next     = !total_reg[0] && !ovf_reg &&
                                     eff_a[half[epc_pkg::BIT_W-1:0]];
                    odd_next       = total_reg[0];
                    sovf_next      = ovf_reg;
                    out_valid_next = 1'b1;
                    total_next     = '0;
                    ovf_next       = 1'b0;
                    word_vld_next  = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            s_reg         <= '0;
            i_reg         <= '0;
            ws_reg        <= '0;
            bs_reg        <= '0;
            word_vld_reg  <= '0;
            wr_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            s_reg         <= s_next;
            i_reg         <= i_next;
            ws_reg        <= ws_next;
            bs_reg        <= bs_next;
            word_vld_reg  <= word_vld_next;
            wr_vld_reg    <= wr_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg  <= a_addr;
        b_addr_reg  <= i_reg;
        a_vld_reg   <= word_vld_reg[a_addr];
        b_vld_reg   <= word_vld_reg[i_reg];
        lo_zero_reg <= (s_reg == '0);
        hi_reg      <= eff_a;
        split_reg   <= split_next;
        odd_reg     <= odd_next;
        sovf_reg    <= sovf_next;
    end

    assign out_valid    = out_valid_reg;
    assign can_split    = split_reg;
    assign total_odd    = odd_reg;
    assign sum_overflow = sovf_reg;

endmodule

>>> rtl/epc_checker.sv
// Port-level checker for the equal partition checker, bound to the top level.
// Depends on epc_pkg and equal_partition_checker_assert.svh.
`include "equal_partition_checker_assert.svh"

module epc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic [epc_pkg::VALUE_WIDTH-1:0] value,
    input logic                            last,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            can_split,
    input logic                            total_odd,
    input logic                            sum_overflow
);

    logic [2:0] result_bits;
    logic       busy_request;

    assign result_bits  = {can_split, total_odd, sum_overflow};
    assign busy_request = in_valid && in_ready && ((value != '0) || last);

    `EPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bits))
    `EPC_ASSERT_SAME(a_split_consistent, out_valid && can_split, !total_odd && !sum_overflow)
    `EPC_ASSERT_NEXT(a_busy_after_request, busy_request, !in_ready)
    `EPC_ASSERT_SAME(a_result_after_work, $rose(out_valid), !$past(in_ready))

endmodule

bind equal_partition_checker epc_checker u_epc_checker (.*);

>>> tb/sv/equal_partition_checker_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for equal_partition_checker: it streams sets of values and checks
// each split verdict against a subset-sum bitset predictor kept inside the testbench.
// Depends on epc_pkg and the equal_partition_checker RTL.
module equal_partition_checker_test;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam int RANDOM_END   = 546;
    localparam int TOTAL_ITEMS  = 750;

    typedef struct packed {
        logic can_split;
        logic total_odd;
        logic sum_overflow;
    } verdict_t;

    typedef logic [epc_pkg::VALUE_WIDTH-1:0] value_q_t[$];

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    logic [epc_pkg::VALUE_WIDTH-1:0] value     = '0;
    logic                            last      = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            can_split;
    logic                            total_odd;
    logic                            sum_overflow;

    logic [epc_pkg::MAX_TOTAL:0] sums_seen = 1;
    int unsigned                 sum_total = 0;
    bit                          sum_ovf   = 1'b0;
    verdict_t                    expected_verdicts[$];

    int errors         = 0;
    int requests_sent  = 0;
    int sets_sent      = 0;
    int verdicts_seen  = 0;
    int splits_seen    = 0;
    int odd_seen       = 0;
    int overflows_seen = 0;
    int stall_count    = 0;
    int hold_cycles    = 0;
    bit tx_idle_en     = 1'b1;
    bit rx_idle_en     = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    equal_partition_checker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .can_split    (can_split),
        .total_odd    (total_odd),
        .sum_overflow (sum_overflow)
    );

    function automatic void absorb_value(logic [epc_pkg::VALUE_WIDTH-1:0] v, logic l);
        verdict_t vd;
        sums_seen = sums_seen | (sums_seen << v);
        if (!sum_ovf && (sum_total + v > epc_pkg::MAX_TOTAL))
            sum_ovf = 1'b1;
        sum_total += v;
        if (l)
        begin
            vd.total_odd    = sum_total[0];
            vd.sum_overflow = sum_ovf;
            vd.can_split    = (!vd.total_odd && !sum_ovf) ? sums_seen[sum_total >> 1] : 1'b0;
            expected_verdicts.push_back(vd);
            sums_seen = 1;
            sum_total = 0;
            sum_ovf   = 1'b0;
        end
    endfunction

    function automatic value_q_t random_set(int max_len);
        value_q_t s;
        int mode;
        int len;
        int j;
        logic [epc_pkg::VALUE_WIDTH-1:0] v;
        mode = $urandom_range(0, 4);
        len  = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: s.push_back(epc_pkg::VALUE_WIDTH'($urandom_range(0, 15)));
                1: s.push_back(epc_pkg::VALUE_WIDTH'($urandom_range(0, 63)));
                2: s.push_back(epc_pkg::VALUE_WIDTH'($urandom_range(0, 255)));
                3: s.push_back(epc_pkg::VALUE_WIDTH'($urandom_range(200, 255)));
                default:
                begin
                    v = epc_pkg::VALUE_WIDTH'($urandom_range(0, 127));
                    s.push_back(v);
                    s.push_back(v);
                end
            endcase
        end
        for (int i = s.size() - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            v    = s[i];
            s[i] = s[j];
            s[j] = v;
        end
        return s;
    endfunction

    task automatic report_mismatch(string what, logic got, logic want);
        $display("MISMATCH %s: got %b, expected %b", what, got, want);
        errors++;
    endtask

    task automatic send_request(logic [epc_pkg::VALUE_WIDTH-1:0] v, logic l);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_value(v, l);
        requests_sent++;
        if (l)
            sets_sent++;
    endtask

    task automatic send_repeat(logic [epc_pkg::VALUE_WIDTH-1:0] v, int n);
        for (int i = 0; i < n; i++)
            send_request(v, i == n - 1);
    endtask

    task automatic send_set(value_q_t s);
        foreach (s[i])
            send_request(s[i], i == s.size() - 1);
    endtask

    task automatic test_directed_sets;
        send_repeat(8'd0, 1);
        send_repeat(8'd255, 1);
        send_repeat(8'd0, 2);
        send_repeat(8'd1, 2);
        send_request(8'd3, 1'b0);
        send_request(8'd1, 1'b0);
        send_request(8'd1, 1'b0);
        send_request(8'd1, 1'b1);
        send_request(8'd2, 1'b0);
        send_request(8'd4, 1'b1);
        send_repeat(8'd200, 6);
        send_repeat(8'd128, 8);
    endtask

    task automatic test_random_sets;
        while (requests_sent < RANDOM_END)
            send_set(random_set(10));
    endtask

    task automatic test_receiver_hold;
        hold_cycles = HOLD_CYCLES;
        repeat (30)
            send_set(random_set(2));
    endtask

    task automatic test_steady_stream;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        while (requests_sent < TOTAL_ITEMS)
            send_set(random_set(10));
    endtask

    initial
    begin
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
                out_ready  <= 1'b0;
                while (n > 0)
                begin
                    @(posedge clk);
                    n--;
                end
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch("result with no set pending", can_split, 1'b0);
            else
            begin
                want = expected_verdicts.pop_front();
                if (can_split !== want.can_split)
                    report_mismatch("can_split", can_split, want.can_split);
                if (total_odd !== want.total_odd)
                    report_mismatch("total_odd", total_odd, want.total_odd);
                if (sum_overflow !== want.sum_overflow)
                    report_mismatch("sum_overflow", sum_overflow, want.sum_overflow);
                verdicts_seen++;
                splits_seen    += want.can_split;
                odd_seen       += want.total_odd;
                overflows_seen += want.sum_overflow;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("Timed out: no request moved for %0d cycles", STALL_LIMIT);
            $display("equal_partition_checker_test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_sets;
        test_random_sets;
        test_receiver_hold;
        test_steady_stream;
        in_valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d verdicts (%0d splits, %0d odd, %0d overflow) from %0d requests.",
                 verdicts_seen, splits_seen, odd_seen, overflows_seen, requests_sent);
        $display("Covered %0d sets: edge values, mirrored sets, a long hold, a gap-free stream.",
                 sets_sent);
        if (errors == 0)
            $display("equal_partition_checker_test passed");
        else
            $display("equal_partition_checker_test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/epc_pkg.sv
rtl/epc_ram.sv
rtl/equal_partition_checker.sv
rtl/epc_checker.sv
tb/sv/equal_partition_checker_test.sv
